### rtl/khash_pkg.sv
// Package for the keyword hash table: sizes, codes, request/response types.
// Used by every module of the block but khash_ram; depends on nothing.
package khash_pkg;

    // Table geometry; TABLE_SLOTS must be a power of two
    localparam int TABLE_SLOTS = 256;
    localparam int PREFIX_LEN  = 8;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);

    // Lanes: one per key byte
    localparam int LANES   = 8;
    localparam int LANE_W  = 3;
    localparam int BYTE_W  = 8;
    // Widest lane term: c + (c << 7)
    localparam int TERM_W  = BYTE_W + LANES;
    // Sum of all lane terms
    localparam int HASH_W  = TERM_W + LANE_W;

    localparam int ENTRY_W = 49;

    // Operation codes
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISS    = 2'd1;
    localparam logic [1:0] ST_COLLIDE = 2'd2;

    typedef struct packed {
        logic        operation;
        logic [63:0] key_bytes;
        logic [7:0]  key_len;
        logic [15:0] open_code;
        logic [15:0] close_code;
        logic [15:0] attr_code;
        logic        extra_flag;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  slot;
        logic [15:0] found_open;
        logic [15:0] found_close;
        logic [15:0] found_attr;
        logic        found_flag;
    } resp_t;

    // Stored entry: open, close, attr, flag from high bits to low
    typedef struct packed {
        logic [15:0] open_code;
        logic [15:0] close_code;
        logic [15:0] attr_code;
        logic        flag;
    } entry_t;

    typedef logic [LANES-1:0][TERM_W-1:0] term_arr_t;

endpackage

### rtl/khash_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package needed.
module khash_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port: hold data until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/khash_lane.sv
// One hash lane: weighs one key byte by its position and registers the term.
// Depends on khash_pkg.
module khash_lane
    import khash_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [LANE_W-1:0] lane_idx,
    input  logic [BYTE_W-1:0] key_byte,
    input  logic [7:0]        key_len,
    output logic [TERM_W-1:0] term
);

    logic              active;
    logic [TERM_W-1:0] ext_byte;
    logic [TERM_W-1:0] term_next;
    logic [TERM_W-1:0] term_reg;

    // Count the byte only inside both the key and the hashed prefix
    assign active = (8'(lane_idx) < key_len) &&
                    ((LANE_W + 1)'(lane_idx) < (LANE_W + 1)'(PREFIX_LEN));

    assign ext_byte  = TERM_W'(key_byte);
    assign term_next = active ? (ext_byte + (ext_byte << lane_idx)) : '0;

    // Hold the term for the merge stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            term_reg <= term_next;
        end
    end

    assign term = term_reg;

endmodule

### rtl/khash_merge.sv
// Merge stage: adds the lane terms and registers the slot index.
// Depends on khash_pkg.
module khash_merge
    import khash_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  term_arr_t         terms,
    output logic [SLOT_W-1:0] slot
);

    logic [HASH_W-1:0] hash_sum;
    logic [SLOT_W-1:0] slot_reg;

    // Sum the lane terms
    always_comb
    begin
        hash_sum = '0;
        for (int i = 0; i < LANES; i++)
        begin
            hash_sum = hash_sum + HASH_W'(terms[i]);
        end
    end

    // Reduce mod the slot count and hold
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            slot_reg <= hash_sum[SLOT_W-1:0];
        end
    end

    assign slot = slot_reg;

endmodule

### rtl/keyword_hash_table.sv
// Keyword hash table: top level with sequencer, valid bits and response register.
// Depends on khash_pkg, khash_lane, khash_merge and khash_ram.
//
// Each request is hashed by eight byte lanes, one per key byte, whose terms a
// merge stage adds into the slot index; the slot entry then comes from a RAM
// with registered read and its valid bit from a flip-flop vector cleared at
// reset. One request is in flight at a time: the response is registered after
// the lane, merge, RAM read and decide steps, and the sequencer then returns
// to idle before it takes the next request. A response waiting to be taken
// does not block a new request; it only holds the decide step. Keys are not
// compared: any non-empty key that hashes to an occupied slot hits, and an
// insert into an occupied slot reports a collision and leaves the slot unchanged.
module keyword_hash_table
    import khash_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    output logic  req_stall,
    input  req_t  req_data,
    output logic  resp_valid,
    input  logic  resp_stall,
    output resp_t resp_data
);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_HASH = 3'd1;
    localparam logic [2:0] PH_SUM  = 3'd2;
    localparam logic [2:0] PH_READ = 3'd3;
    localparam logic [2:0] PH_DONE = 3'd4;

    logic [2:0]             phase_reg, phase_next;
    req_t                   req_reg;
    logic [TABLE_SLOTS-1:0] valid_reg;
    logic                   hit_reg;
    logic                   resp_valid_reg;
    resp_t                  resp_reg, resp_next;

    logic                   req_take;
    logic                   resp_take;
    logic                   finish;
    logic                   empty_key;
    logic                   ram_we;
    term_arr_t              terms;
    logic [SLOT_W-1:0]      slot_idx;
    entry_t                 new_entry;
    entry_t                 old_entry;
    logic [ENTRY_W-1:0]     ram_rdata;

    assign req_take  = req_valid && !req_stall;
    assign resp_take = resp_valid_reg && !resp_stall;
    assign req_stall = (phase_reg != PH_IDLE);
    assign finish    = (phase_reg == PH_DONE) && (!resp_valid_reg || !resp_stall);

    // Capture the request
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            req_reg <= req_data;
        end
    end

    // Byte lanes
    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        khash_lane u_lane (
            .clk      (clk),
            .en       (phase_reg == PH_HASH),
            .lane_idx (LANE_W'(g)),
            .key_byte (req_reg.key_bytes[g*BYTE_W +: BYTE_W]),
            .key_len  (req_reg.key_len),
            .term     (terms[g])
        );
    end

    khash_merge u_merge (
        .clk   (clk),
        .en    (phase_reg == PH_SUM),
        .terms (terms),
        .slot  (slot_idx)
    );

    assign empty_key = (req_reg.key_len == 8'd0);
    assign new_entry = '{open_code:  req_reg.open_code,
                         close_code: req_reg.close_code,
                         attr_code:  req_reg.attr_code,
                         flag:       req_reg.extra_flag};
    assign old_entry = entry_t'(ram_rdata);

    // Store only a new entry into an empty slot
    assign ram_we = finish && !empty_key && (req_reg.operation == OP_INSERT) && !hit_reg;

    khash_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_idx),
        .wdata (ENTRY_W'(new_entry)),
        .re    (phase_reg == PH_READ),
        .raddr (slot_idx),
        .rdata (ram_rdata)
    );

    // Advance the sequencer
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_IDLE: if (req_take) phase_next = PH_HASH;
            PH_HASH: phase_next = PH_SUM;
            PH_SUM:  phase_next = PH_READ;
            PH_READ: phase_next = PH_DONE;
            PH_DONE: if (finish) phase_next = PH_IDLE;
            default: phase_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    // Read the valid bit alongside the entry
    always_ff @(posedge clk)
    begin
        if (phase_reg == PH_READ)
        begin
            hit_reg <= valid_reg[slot_idx];
        end
    end

    // Mark slots as they fill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ram_we)
        begin
            valid_reg[slot_idx] <= 1'b1;
        end
    end

    // Build the response
    always_comb
    begin
        resp_next             = '0;
        resp_next.status      = ST_MISS;
        if (!empty_key)
        begin
            resp_next.slot = 8'(slot_idx);
            if (hit_reg)
            begin
                resp_next.status      = (req_reg.operation == OP_INSERT) ? ST_COLLIDE : ST_OK;
                resp_next.found_open  = old_entry.open_code;
                resp_next.found_close = old_entry.close_code;
                resp_next.found_attr  = old_entry.attr_code;
                resp_next.found_flag  = old_entry.flag;
            end
            else if (req_reg.operation == OP_INSERT)
            begin
                resp_next.status      = ST_OK;
                resp_next.found_open  = new_entry.open_code;
                resp_next.found_close = new_entry.close_code;
                resp_next.found_attr  = new_entry.attr_code;
                resp_next.found_flag  = new_entry.flag;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            resp_reg <= resp_next;
        end
    end

    // Hold the response until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resp_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            resp_valid_reg <= 1'b1;
        end
        else if (resp_take)
        begin
            resp_valid_reg <= 1'b0;
        end
    end

    assign resp_valid = resp_valid_reg;
    assign resp_data  = resp_reg;

`ifndef SYNTHESIS
    a_take_starts_hash: assert property (@(posedge clk) disable iff (!rst_n)
        req_take |=> (phase_reg == PH_HASH))
        else $error("request taken without starting the hash");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !valid_reg[slot_idx])
        else $error("insert overwrote an occupied slot");

    a_resp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(resp_valid_reg) |-> $past(phase_reg == PH_DONE))
        else $error("response raised outside the decide step");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        resp_valid_reg |-> (resp_reg.status == ST_OK || resp_reg.status == ST_MISS ||
                            resp_reg.status == ST_COLLIDE))
        else $error("undefined response status");
`endif

endmodule
